[rtl/eau_pkg.sv]
package eau_pkg;

  localparam int RegCount = 16;
  localparam int RegAw    = $clog2(RegCount);

  localparam logic       REQ_COMPUTE = 1'b0;
  localparam logic       REQ_WRITE   = 1'b1;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  // Mode groups, taken from mode bits 5:3.
  localparam logic [2:0] GRP_DREG    = 3'd0;
  localparam logic [2:0] GRP_AREG    = 3'd1;
  localparam logic [2:0] GRP_IND     = 3'd2;
  localparam logic [2:0] GRP_POSTINC = 3'd3;
  localparam logic [2:0] GRP_PREDEC  = 3'd4;
  localparam logic [2:0] GRP_DISP    = 3'd5;
  localparam logic [2:0] GRP_INDEX   = 3'd6;
  localparam logic [2:0] GRP_SPECIAL = 3'd7;

  localparam logic [5:0] MODE_ABS_SHORT = 6'h38;
  localparam logic [5:0] MODE_ABS_LONG  = 6'h39;
  localparam logic [5:0] MODE_PC_DISP   = 6'h3a;
  localparam logic [5:0] MODE_PC_INDEX  = 6'h3b;
  localparam logic [5:0] MODE_IMMEDIATE = 6'h3c;

  typedef enum logic [1:0] {
    KIND_REG  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_PROG = 2'd2,
    KIND_IMM  = 2'd3
  } kind_t;

  // One request as held in the input register.
  typedef struct packed {
    logic              req_type;
    logic [5:0]        mode;
    logic [1:0]        size;
    logic [15:0]       ext_first;
    logic [15:0]       ext_second;
    logic [31:0]       ext_pc;
    logic [31:0]       write_value;
    logic [RegAw-1:0]  addr_a;
  } item_t;

  typedef struct packed {
    logic [31:0]       result_value;
    logic [3:0]        reg_index;
    kind_t             operand_kind;
    logic              invalid_mode;
    logic              writable;
    logic [1:0]        words_used;
    logic [4:0]        extra_cycles;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [RegAw-1:0]  addr;
    logic [31:0]       data;
  } reg_wr_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    sx8 = {{24{v[7]}}, v};
  endfunction

endpackage

[rtl/eau_ram.sv]
module eau_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int Aw = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [Aw-1:0]    wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic             rd_en,
  input  logic [Aw-1:0]    rd_addr,
  output logic [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/eau_field.sv]
module eau_field
  import eau_pkg::*;
(
  input  logic             req_type,
  input  logic [5:0]       mode,
  input  logic [15:0]      field_mask,
  input  logic [15:0]      opcode,
  input  logic [3:0]       write_index,
  output logic [RegAw-1:0] addr
);

  logic [3:0]  low;
  logic [15:0] sel_bits;
  logic [15:0] mask_sh;
  logic [3:0]  idx;
  logic [3:0]  code;
  logic        wide;
  logic        force_a;
  logic        need;

  // The field starts at the lowest set bit of the mask, bit 15 if none is set.
  always_comb begin
    low = 4'd15;
    for (int i = 14; i >= 0; i--) begin
      if (field_mask[i]) begin
        low = 4'(i);
      end
    end
  end

  always_comb begin
    sel_bits = (opcode & field_mask) >> low;
    mask_sh  = field_mask >> low;
    idx      = sel_bits[3:0] & mask_sh[3:0];
    wide     = mask_sh[3];
    // Modes from 0x28 up (displacement, indexed and special) decide as if the mode were 8.
    code     = (mode >= 6'h28) ? 4'd8 : mode[3:0];
    force_a  = (mode[5:3] == GRP_INDEX);
    need     = (((mode >= 6'h08) && (mode < 6'h28)) || (mode >= 6'h28)) &&
               !(wide && code[3]);
    if (force_a) begin
      need = 1'b1;
    end
    if (req_type == REQ_WRITE) begin
      addr = write_index;
    end else begin
      addr = {idx[3] | need, idx[2:0]};
    end
  end

endmodule

[rtl/eau_calc.sv]
module eau_calc
  import eau_pkg::*;
(
  input  item_t       item,
  input  logic [31:0] opa,
  input  logic [31:0] opb,
  output result_t     res,
  output reg_wr_t     wr
);

  logic        small_sz;
  logic [31:0] step;
  logic [31:0] xn;
  logic [31:0] idx_term;
  logic [31:0] base;
  logic [31:0] offs;
  logic [31:0] merged;
  logic [31:0] imm;

  always_comb begin
    small_sz = (item.size == SIZE_BYTE) || (item.size == SIZE_WORD);

    if (item.size == SIZE_BYTE) begin
      step = (item.mode[2:0] == 3'd7) ? 32'd2 : 32'd1;
    end else if (item.size == SIZE_WORD) begin
      step = 32'd2;
    end else begin
      step = 32'd4;
    end

    // Index register is a sign-extended word unless bit 11 asks for long.
    xn       = item.ext_first[11] ? opb : sx16(opb[15:0]);
    idx_term = xn + sx8(item.ext_first[7:0]);

    if (item.size == SIZE_BYTE) begin
      merged = {opa[31:8], item.write_value[7:0]};
      imm    = sx8(item.ext_first[7:0]);
    end else if (item.size == SIZE_WORD) begin
      merged = {opa[31:16], item.write_value[15:0]};
      imm    = sx16(item.ext_first);
    end else begin
      merged = item.write_value;
      imm    = {item.ext_first, item.ext_second};
    end
  end

  always_comb begin
    res      = '0;
    wr.en    = 1'b0;
    wr.addr  = item.addr_a;
    wr.data  = merged;
    base     = '0;
    offs     = '0;

    if (item.req_type == REQ_WRITE) begin
      wr.en            = 1'b1;
      res.reg_index    = item.addr_a;
      res.writable     = 1'b1;
    end else if (item.mode > MODE_IMMEDIATE) begin
      res.invalid_mode = 1'b1;
    end else if (item.mode == MODE_IMMEDIATE) begin
      res.operand_kind = KIND_IMM;
      res.words_used   = (small_sz) ? 2'd1 : 2'd2;
      base             = imm;
    end else begin
      res.writable = 1'b1;
      unique case (item.mode[5:3])
        GRP_DREG, GRP_AREG: begin
          res.reg_index = item.addr_a;
        end
        GRP_IND, GRP_POSTINC: begin
          res.operand_kind = KIND_DATA;
          res.reg_index    = item.addr_a;
          res.extra_cycles = small_sz ? 5'd4 : 5'd8;
          base             = opa;
          wr.en            = (item.mode[5:3] == GRP_POSTINC);
          wr.data          = opa + step;
        end
        GRP_PREDEC: begin
          res.operand_kind = KIND_DATA;
          res.reg_index    = item.addr_a;
          res.extra_cycles = small_sz ? 5'd6 : 5'd10;
          base             = opa;
          offs             = -step;
          wr.en            = 1'b1;
          wr.data          = opa - step;
        end
        GRP_DISP: begin
          res.operand_kind = KIND_DATA;
          res.reg_index    = item.addr_a;
          res.words_used   = 2'd1;
          res.extra_cycles = small_sz ? 5'd8 : 5'd12;
          base             = opa;
          offs             = sx16(item.ext_first);
        end
        GRP_INDEX: begin
          res.operand_kind = KIND_DATA;
          res.reg_index    = item.addr_a;
          res.words_used   = 2'd1;
          res.extra_cycles = small_sz ? 5'd10 : 5'd14;
          base             = opa;
          offs             = idx_term;
        end
        GRP_SPECIAL: begin
          unique case (item.mode)
            MODE_ABS_SHORT: begin
              res.operand_kind = KIND_DATA;
              res.words_used   = 2'd1;
              res.extra_cycles = small_sz ? 5'd8 : 5'd12;
              base             = sx16(item.ext_first);
            end
            MODE_ABS_LONG: begin
              res.operand_kind = KIND_DATA;
              res.words_used   = 2'd2;
              res.extra_cycles = small_sz ? 5'd12 : 5'd16;
              base             = {item.ext_first, item.ext_second};
            end
            MODE_PC_DISP: begin
              res.operand_kind = KIND_PROG;
              res.words_used   = 2'd1;
              res.extra_cycles = small_sz ? 5'd8 : 5'd12;
              base             = item.ext_pc;
              offs             = sx16(item.ext_first);
            end
            default: begin
              res.operand_kind = KIND_PROG;
              res.words_used   = 2'd1;
              res.extra_cycles = small_sz ? 5'd10 : 5'd14;
              base             = item.ext_pc;
              offs             = idx_term;
            end
          endcase
        end
        default: begin
          res.reg_index = item.addr_a;
        end
      endcase
    end

    if (item.req_type == REQ_WRITE) begin
      res.result_value = merged;
    end else begin
      res.result_value = base + offs;
    end
  end

endmodule

[rtl/m68k_effective_address_unit.sv]
// 68000 effective-address unit with its own sixteen-entry register file
// (D0-D7 then A0-A7).
// Requests arrive on the s_axis channel: tuser carries the request type
// (compute address or write register), tdata the operand fields. Each
// request yields exactly one transaction on the m_axis channel, with the
// operand kind on tuser and the address, immediate or merged register
// value plus the decode results on tdata.
// One request is taken every cycle while the receiver does not stall: the
// register index is decoded and both register-file ports are read while the
// request is captured, and the result is formed and the register updated as
// the request moves on to the output register. A one-entry bypass covers a
// request that reads the register written by the request just ahead of it.
// When the receiver stalls, the output register holds its result, one more
// request may wait in the input register, and s_axis_tready then drops.
// Reset empties both stages and marks every register of the file as zero;
// no clearing pass is needed.
module m68k_effective_address_unit
  import eau_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [5:0] mode, [7:6] size, [23:8] field_mask, [39:24] opcode,
  // [55:40] ext_first, [71:56] ext_second, [103:72] ext_pc,
  // [107:104] write_index, [139:108] write_value, [143:140] zero
  input  logic [143:0] s_axis_tdata,
  // [0] req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] result_value, [35:32] reg_index, [36] invalid_mode,
  // [37] writable, [39:38] words_used, [44:40] extra_cycles, [47:45] zero
  output logic [47:0]  m_axis_tdata,
  // [1:0] operand_kind
  output logic [1:0]   m_axis_tuser
);

  logic              in_accept;
  logic              s1_valid;
  logic              s1_adv;
  item_t             s1;
  item_t             item_next;
  logic [RegAw-1:0]  addr_a;
  logic [RegAw-1:0]  addr_b;
  logic [31:0]       qa;
  logic [31:0]       qb;
  logic              va;
  logic              vb;
  logic [RegCount-1:0] reg_valid;
  reg_wr_t           fwd;
  reg_wr_t           wr;
  logic              wr_now;
  logic [31:0]       opa;
  logic [31:0]       opb;
  result_t           res;
  result_t           out;
  logic              out_valid;

  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign wr_now        = s1_adv && wr.en;

  eau_field u_field (
    .req_type    (s_axis_tuser),
    .mode        (s_axis_tdata[5:0]),
    .field_mask  (s_axis_tdata[23:8]),
    .opcode      (s_axis_tdata[39:24]),
    .write_index (s_axis_tdata[107:104]),
    .addr        (addr_a)
  );

  assign addr_b = s_axis_tdata[55:52];

  always_comb begin
    item_next.req_type    = s_axis_tuser;
    item_next.mode        = s_axis_tdata[5:0];
    item_next.size        = s_axis_tdata[7:6];
    item_next.ext_first   = s_axis_tdata[55:40];
    item_next.ext_second  = s_axis_tdata[71:56];
    item_next.ext_pc      = s_axis_tdata[103:72];
    item_next.write_value = s_axis_tdata[139:108];
    item_next.addr_a      = addr_a;
  end

  // Two copies of the register file give two independent read ports.
  eau_ram #(.Width(32), .Depth(RegCount)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_now),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (in_accept),
    .rd_addr (addr_a),
    .rd_data (qa)
  );

  eau_ram #(.Width(32), .Depth(RegCount)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_now),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (in_accept),
    .rd_addr (addr_b),
    .rd_data (qb)
  );

  // The bypass entry records the write made at the edge that captured the
  // current request, which the memory read at that edge did not see yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      reg_valid <= '0;
      fwd.en    <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (wr_now) begin
        reg_valid[wr.addr] <= 1'b1;
      end
      if (in_accept) begin
        fwd.en   <= wr_now;
        fwd.addr <= wr.addr;
        fwd.data <= wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1       <= item_next;
      va       <= reg_valid[addr_a];
      vb       <= reg_valid[addr_b];
    end
  end

  always_comb begin
    if (fwd.en && (fwd.addr == s1.addr_a)) begin
      opa = fwd.data;
    end else begin
      opa = va ? qa : '0;
    end
    if (fwd.en && (fwd.addr == s1.ext_first[15:12])) begin
      opb = fwd.data;
    end else begin
      opb = vb ? qb : '0;
    end
  end

  eau_calc u_calc (
    .item (s1),
    .opa  (opa),
    .opb  (opb),
    .res  (res),
    .wr   (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out.operand_kind;
  assign m_axis_tdata  = {3'b000, out.extra_cycles, out.words_used, out.writable,
                          out.invalid_mode, out.reg_index, out.result_value};

endmodule
